>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lat_pkg.sv
// ---------------------------------------------------------------------------
// Landmark association package
// Shared widths, constants, state codes and CORDIC tables.
// ---------------------------------------------------------------------------
package lat_pkg;

  localparam int unsigned LANDMARK_DEPTH_DEF = 256;
  localparam int unsigned POS_W = 24;
  localparam int unsigned ANG_W = 16;
  localparam int unsigned CFG_W = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CORDIC_W = 48;
  localparam int unsigned Z_W = 26;
  localparam int unsigned STEPS = 16;
  localparam int unsigned STEP_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_THR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TSTEP = 1'b1;
  localparam logic [15:0] THR_RESET = 16'd2048;
  localparam logic [15:0] TSTEP_RESET = 16'd1311;
  localparam logic [16:0] GAIN_INV = 17'd39797;
  localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = -24'sh800000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ROT, ST_GAIN, ST_SCALE, ST_POSE, ST_SCAN, ST_CMP, ST_BLEND,
    ST_DIV, ST_WRITE, ST_DONE
  } lat_state_t;

  typedef struct packed {
    logic       start;
    logic       busy;
  } cordic_ctl_t;

  function automatic logic [Z_W-1:0] atan_lut(input logic [STEP_W-1:0] i);
    logic [Z_W-1:0] v;
    case (i)
      4'd0: v = 26'd2097152;  4'd1: v = 26'd1238021;
      4'd2: v = 26'd654136;   4'd3: v = 26'd332050;
      4'd4: v = 26'd166669;   4'd5: v = 26'd83416;
      4'd6: v = 26'd41718;    4'd7: v = 26'd20860;
      4'd8: v = 26'd10430;    4'd9: v = 26'd5215;
      4'd10: v = 26'd2608;    4'd11: v = 26'd1304;
      4'd12: v = 26'd652;     4'd13: v = 26'd326;
      4'd14: v = 26'd163;     default: v = 26'd81;
    endcase
    return v;
  endfunction

  function automatic logic signed [POS_W-1:0] sat24(input logic signed [49:0] v);
    logic signed [POS_W-1:0] r;
    if (v > 50'sd8388607) r = POS_MAX;
    else if (v < -50'sd8388608) r = POS_MIN;
    else r = v[POS_W-1:0];
    return r;
  endfunction

endpackage

>>> rtl/lat_if.sv
// ---------------------------------------------------------------------------
// Landmark association channels
// Valid/ready interfaces for odometry and observation beats and result beats.
// ---------------------------------------------------------------------------
interface lat_in_if;
  logic              valid;
  logic              ready;
  logic              mode;
  logic signed [15:0] vel_forward;
  logic signed [15:0] vel_lateral;
  logic signed [15:0] yaw_rate;
  logic [15:0]       obs_range;
  logic [15:0]       obs_bearing;
  logic [1:0]        cone_color;
  modport source (output valid, mode, vel_forward, vel_lateral, yaw_rate, obs_range,
                  obs_bearing, cone_color, input ready);
  modport sink (input valid, mode, vel_forward, vel_lateral, yaw_rate, obs_range,
                obs_bearing, cone_color, output ready);
endinterface

interface lat_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         landmark_index;
  logic               matched;
  logic               newly_verified;
  logic               table_full;
  logic signed [23:0] pose_x;
  logic signed [23:0] pose_y;
  logic [15:0]        pose_heading;
  modport source (output valid, landmark_index, matched, newly_verified, table_full,
                  pose_x, pose_y, pose_heading, input ready);
  modport sink (input valid, landmark_index, matched, newly_verified, table_full,
                pose_x, pose_y, pose_heading, output ready);
endinterface

>>> rtl/lat_cordic.sv
// ---------------------------------------------------------------------------
// Landmark association CORDIC
// Rotates a vector by a binary angle, one micro-rotation per cycle.
// ---------------------------------------------------------------------------
module lat_cordic
  import lat_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  cordic_ctl_t                ctl,
  input  logic signed [16:0]         vec_x,
  input  logic signed [16:0]         vec_y,
  input  logic [ANG_W-1:0]           angle,
  output logic                       done,
  output logic signed [CORDIC_W-1:0] res_x,
  output logic signed [CORDIC_W-1:0] res_y
);

  logic signed [CORDIC_W-1:0] cx_r, cy_r;
  logic signed [Z_W-1:0]      z_r;
  logic [STEP_W-1:0]          step_r;
  logic                       run_r;
  logic [ANG_W-1:0]           a_fold;
  logic                       flip;
  logic signed [CORDIC_W-1:0] sx, sy;

  always_comb begin
    flip = ((angle + 16'd16384) >= 16'd32768);
    a_fold = flip ? angle + 16'd32768 : angle;
    sx = cx_r >>> step_r;
    sy = cy_r >>> step_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      step_r <= '0;
    end else if (ctl.start) begin
      run_r <= 1'b1;
      step_r <= '0;
      cx_r <= flip ? -(CORDIC_W'(vec_x) <<< 14) : (CORDIC_W'(vec_x) <<< 14);
      cy_r <= flip ? -(CORDIC_W'(vec_y) <<< 14) : (CORDIC_W'(vec_y) <<< 14);
      z_r <= Z_W'($signed(a_fold)) <<< 8;
    end else if (run_r) begin
      if (z_r >= 0) begin
        cx_r <= cx_r - sy;
        cy_r <= cy_r + sx;
        z_r <= z_r - $signed(atan_lut(step_r));
      end else begin
        cx_r <= cx_r + sy;
        cy_r <= cy_r - sx;
        z_r <= z_r + $signed(atan_lut(step_r));
      end
      step_r <= step_r + 1'b1;
      if (step_r == STEP_W'(STEPS - 1)) run_r <= 1'b0;
    end
  end

  assign done = run_r && (step_r == STEP_W'(STEPS - 1));
  assign res_x = cx_r;
  assign res_y = cy_r;

endmodule

>>> rtl/landmark_association_table.sv
// ---------------------------------------------------------------------------
// Landmark association table
// Dead-reckoned pose with nearest-neighbor gated landmark association.
// ---------------------------------------------------------------------------
// Channel | Direction | Beat contents
// in      | sink      | mode, velocities, yaw rate, range, bearing, color
// out     | source    | landmark index, flags, pose
// cfg     | write     | gate radius and odometry period
// A beat is taken only in the idle state, so the next beat waits until the
// last one has reached the result; an observation beat walks the landmark
// memory in turn through one shared distance datapath, which subtracts and
// then compares each entry. The CORDIC unit rotates the input first.
// Reset is synchronous; no clearing pass. A result waiting at the output lets
// the next beat in; that beat waits in its last state until the result leaves.
module landmark_association_table
  import lat_pkg::*;
#(
  parameter int unsigned LANDMARK_DEPTH = LANDMARK_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  lat_in_if.sink               in_ch,
  lat_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);
`include "assert_macros.svh"

  localparam int unsigned IDX_W = $clog2(LANDMARK_DEPTH);

  lat_state_t state_r, state_nxt;
  logic [15:0] thr_r, tstep_r;
  logic signed [POS_W-1:0] rx_r, ry_r;
  logic [ANG_W-1:0] head_r;
  logic [IDX_W:0] count_r;
  logic mode_r;
  logic [1:0] col_r;
  logic signed [15:0] yaw_r;
  logic signed [16:0] vx_in, vy_in;
  logic [ANG_W-1:0] ang_in;
  logic signed [CORDIC_W-1:0] gx_r, gy_r;
  logic signed [POS_W-1:0] ox_r, oy_r;
  logic [IDX_W:0] scan_r;
  logic [IDX_W-1:0] best_i_r;
  logic found_r;
  logic [55:0] best_r;
  logic signed [POS_W-1:0] mx_q, my_q;
  logic [1:0] mc_q;
  logic mv_q;
  logic signed [POS_W-1:0] mark_x [LANDMARK_DEPTH];
  logic signed [POS_W-1:0] mark_y [LANDMARK_DEPTH];
  logic [1:0] mark_c [LANDMARK_DEPTH];
  logic mark_v [LANDMARK_DEPTH];
  logic [IDX_W-1:0] rd_addr;
  logic signed [POS_W:0] dx_r, dy_r;
  logic signed [30:0] bx_r, by_r;
  logic signed [POS_W-1:0] nx_r, ny_r;
  logic [7:0] res_idx_r;
  logic res_m_r, res_nv_r, res_f_r;
  logic [7:0] o_idx_r;
  logic o_m_r, o_nv_r, o_f_r, o_valid_r;
  logic signed [POS_W-1:0] o_px_r, o_py_r;
  logic [ANG_W-1:0] o_ph_r;
  logic out_load;
  logic sub_r;
  cordic_ctl_t cctl;
  logic cdone;
  logic signed [CORDIC_W-1:0] crx, cry;

  // Signed division by ten, truncating toward zero, by reciprocal multiply.
  function automatic logic signed [POS_W-1:0] div10(input logic signed [30:0] v);
    logic [30:0] mag;
    logic [63:0] prod;
    logic [POS_W-1:0] q;
    mag = v[30] ? 31'(-v) : 31'(v);
    prod = 64'(mag) * 64'd3435973837;
    q = POS_W'(prod >> 35);
    return v[30] ? -$signed(q) : $signed(q);
  endfunction

  lat_cordic u_cordic (
    .clk, .rst_n, .ctl(cctl), .vec_x(vx_in), .vec_y(vy_in), .angle(ang_in),
    .done(cdone), .res_x(crx), .res_y(cry)
  );

  always_comb begin
    cctl.start = (state_r == ST_IDLE) && in_ch.valid;
    cctl.busy = (state_r == ST_ROT);
    in_ch.ready = (state_r == ST_IDLE);
    out_load = (state_r == ST_DONE) && (!o_valid_r || out_ch.ready);
    rd_addr = (((state_r == ST_SCAN) && (scan_r < count_r)) || (state_r == ST_CMP)) ?
              scan_r[IDX_W-1:0] : best_i_r;
    if (in_ch.mode) begin
      vx_in = {1'b0, in_ch.obs_range};
      vy_in = '0;
      ang_in = in_ch.obs_bearing + head_r;
    end else begin
      vx_in = 17'(in_ch.vel_forward);
      vy_in = 17'(in_ch.vel_lateral);
      ang_in = head_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
      tstep_r <= TSTEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THR: thr_r <= cfg_wdata;
        CFG_TSTEP: tstep_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mx_q <= mark_x[rd_addr];
    my_q <= mark_y[rd_addr];
    mc_q <= mark_c[rd_addr];
    mv_q <= mark_v[rd_addr];
    if (state_r == ST_WRITE) begin
      if (found_r) begin
        mark_x[best_i_r] <= nx_r;
        mark_y[best_i_r] <= ny_r;
        mark_v[best_i_r] <= 1'b1;
      end else if (count_r < (IDX_W+1)'(LANDMARK_DEPTH)) begin
        mark_x[count_r[IDX_W-1:0]] <= ox_r;
        mark_y[count_r[IDX_W-1:0]] <= oy_r;
        mark_c[count_r[IDX_W-1:0]] <= col_r;
        mark_v[count_r[IDX_W-1:0]] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (cctl.start) state_nxt = ST_ROT;
      ST_ROT: if (cdone) state_nxt = ST_GAIN;
      ST_GAIN: state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = mode_r ? ST_POSE : ST_DONE;
      ST_POSE: state_nxt = ST_SCAN;
      ST_SCAN: state_nxt = (scan_r >= count_r) ? ST_BLEND : ST_CMP;
      ST_CMP: state_nxt = sub_r ? ST_SCAN : ST_CMP;
      ST_BLEND: state_nxt = ST_DIV;
      ST_DIV: state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_DONE;
      ST_DONE: state_nxt = out_load ? ST_IDLE : ST_DONE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_r <= '0; ry_r <= '0; head_r <= '0; count_r <= '0;
      o_valid_r <= 1'b0; sub_r <= 1'b0;
    end else begin
      if (out_load) o_valid_r <= 1'b1;
      else if (out_ch.ready) o_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (cctl.start) begin
          mode_r <= in_ch.mode;
          col_r <= in_ch.cone_color;
          yaw_r <= in_ch.yaw_rate;
        end
        ST_ROT: ;
        ST_GAIN: begin
          gx_r <= CORDIC_W'((64'(crx) * $signed({1'b0, GAIN_INV})) >>> 16);
          gy_r <= CORDIC_W'((64'(cry) * $signed({1'b0, GAIN_INV})) >>> 16);
        end
        ST_SCALE: begin
          if (mode_r) begin
            ox_r <= sat24(50'(rx_r) + 50'(gx_r >>> 14));
            oy_r <= sat24(50'(ry_r) + 50'(gy_r >>> 14));
          end else begin
            rx_r <= sat24(50'(rx_r) + 50'((64'(gx_r) * $signed({1'b0, tstep_r})) >>> 28));
            ry_r <= sat24(50'(ry_r) + 50'((64'(gy_r) * $signed({1'b0, tstep_r})) >>> 28));
            head_r <= head_r + 16'((34'(yaw_r) * $signed({1'b0, tstep_r})) >>> 16);
          end
        end
        ST_POSE: begin
          scan_r <= '0;
          found_r <= 1'b0;
          best_i_r <= '0;
          best_r <= 56'(thr_r) * 56'(thr_r) * ((col_r == 2'd3) ? 56'd121 : 56'd100);
          sub_r <= 1'b0;
        end
        ST_SCAN: sub_r <= 1'b0;
        ST_CMP: begin
          if (!sub_r) begin
            dx_r <= 25'(ox_r) - 25'(mx_q);
            dy_r <= 25'(oy_r) - 25'(my_q);
            sub_r <= 1'b1;
          end else begin
            if (mc_q == col_r &&
                (56'(50'(dx_r * dx_r) + 50'(dy_r * dy_r)) * 56'd100) < best_r) begin
              best_r <= 56'(50'(dx_r * dx_r) + 50'(dy_r * dy_r)) * 56'd100;
              best_i_r <= scan_r[IDX_W-1:0];
              found_r <= 1'b1;
            end
            scan_r <= scan_r + 1'b1;
          end
        end
        ST_BLEND: begin
          bx_r <= 31'(mx_q) * 31'sd9 + 31'(ox_r);
          by_r <= 31'(my_q) * 31'sd9 + 31'(oy_r);
        end
        ST_DIV: begin
          nx_r <= div10(bx_r);
          ny_r <= div10(by_r);
        end
        ST_WRITE: begin
          res_m_r <= found_r;
          res_nv_r <= found_r && !mv_q;
          res_f_r <= !found_r && (count_r >= (IDX_W+1)'(LANDMARK_DEPTH));
          if (found_r) res_idx_r <= 8'(best_i_r);
          else if (count_r < (IDX_W+1)'(LANDMARK_DEPTH)) begin
            res_idx_r <= 8'(count_r);
            count_r <= count_r + 1'b1;
          end else res_idx_r <= '0;
        end
        ST_DONE: if (out_load) begin
          o_px_r <= rx_r;
          o_py_r <= ry_r;
          o_ph_r <= head_r;
          if (mode_r) begin
            o_idx_r <= res_idx_r; o_m_r <= res_m_r; o_nv_r <= res_nv_r; o_f_r <= res_f_r;
          end else begin
            o_idx_r <= '0; o_m_r <= 1'b0; o_nv_r <= 1'b0; o_f_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid = o_valid_r;
  assign out_ch.landmark_index = o_idx_r;
  assign out_ch.matched = o_m_r;
  assign out_ch.newly_verified = o_nv_r;
  assign out_ch.table_full = o_f_r;
  assign out_ch.pose_x = o_px_r;
  assign out_ch.pose_y = o_py_r;
  assign out_ch.pose_heading = o_ph_r;

  `ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ch.ready, state_r == ST_IDLE, "ready outside idle")
  `ASSERT_IMPL(a_flags, clk, rst_n, o_valid_r, !(o_m_r && o_f_r), "match and full together")
  `ASSERT_NEXT(a_done, clk, rst_n, state_r == ST_DONE, o_valid_r, "result not raised")

endmodule

>>> tb/landmark_association_table_tb.sv
// ---------------------------------------------------------------------------
// Landmark association table testbench
// Drives odometry and cone observation beats through the valid/ready
// channels with random idling on both sides. A scoreboard keeps its own
// pose, landmark table and registers, predicts every result beat and
// compares it field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module landmark_association_table_tb;
  import lat_pkg::*;

  localparam logic MODE_ODOM = 1'b0;
  localparam logic MODE_OBS = 1'b1;
  localparam int TABLE_SIZE = LANDMARK_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic               mode;
    logic signed [15:0] vel_forward;
    logic signed [15:0] vel_lateral;
    logic signed [15:0] yaw_rate;
    logic [15:0]        obs_range;
    logic [15:0]        obs_bearing;
    logic [1:0]         cone_color;
  } beat_in_t;

  typedef struct {
    logic [7:0]         landmark_index;
    logic               matched;
    logic               newly_verified;
    logic               table_full;
    logic signed [23:0] pose_x;
    logic signed [23:0] pose_y;
    logic [15:0]        pose_heading;
  } beat_out_t;

  class association_scoreboard;
    longint     gate_radius;
    longint     tick_period;
    longint     pose_x;
    longint     pose_y;
    logic [15:0] heading;
    longint     cone_x [TABLE_SIZE];
    longint     cone_y [TABLE_SIZE];
    logic [1:0] cone_color [TABLE_SIZE];
    bit         cone_verified [TABLE_SIZE];
    int         cone_count;
    beat_out_t  pending_results [$];
    int         errors;

    function new();
      gate_radius = 2048;
      tick_period = 1311;
      pose_x = 0;
      pose_y = 0;
      heading = 0;
      cone_count = 0;
      errors = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == CFG_THR) gate_radius = value;
      else if (idx == CFG_TSTEP) tick_period = value;
    endfunction

    function longint clamp24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
    endfunction

    function void rotate(longint x, longint y, logic [15:0] ang,
                         output longint rx, output longint ry);
      longint cx, cy, z, nx, ny;
      logic [15:0] a;
      cx = x * 16384;
      cy = y * 16384;
      a = ang;
      if (16'(a + 16'd16384) >= 16'd32768) begin
        cx = -cx;
        cy = -cy;
        a = a + 16'd32768;
      end
      z = longint'($signed(a)) * 256;
      for (int i = 0; i < 16; i++) begin
        if (z >= 0) begin
          nx = cx - (cy >>> i);
          ny = cy + (cx >>> i);
          z -= longint'(atan_step(i));
        end else begin
          nx = cx + (cy >>> i);
          ny = cy - (cx >>> i);
          z += longint'(atan_step(i));
        end
        cx = nx;
        cy = ny;
      end
      rx = (cx * 39797) >>> 16;
      ry = (cy * 39797) >>> 16;
    endfunction

    function int atan_step(int i);
      int steps [16] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
                         20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
      return steps[i];
    endfunction

    function void note_input(beat_in_t b);
      beat_out_t r;
      longint rx, ry, ox, oy, dx, dy, best, d2;
      int hit;
      r = '{default: '0};
      if (b.mode == MODE_ODOM) begin
        rotate(longint'(b.vel_forward), longint'(b.vel_lateral), heading, rx, ry);
        pose_x = clamp24(pose_x + ((rx * tick_period) >>> 28));
        pose_y = clamp24(pose_y + ((ry * tick_period) >>> 28));
        heading = 16'(longint'(heading) + ((longint'(b.yaw_rate) * tick_period) >>> 16));
      end else begin
        rotate(longint'(b.obs_range), 0, 16'(b.obs_bearing + heading), rx, ry);
        ox = clamp24(pose_x + (rx >>> 14));
        oy = clamp24(pose_y + (ry >>> 14));
        best = gate_radius * gate_radius * (b.cone_color == 2'd3 ? 121 : 100);
        hit = -1;
        for (int i = 0; i < cone_count; i++) begin
          if (cone_color[i] == b.cone_color) begin
            dx = ox - cone_x[i];
            dy = oy - cone_y[i];
            d2 = (dx * dx + dy * dy) * 100;
            if (d2 < best) begin
              best = d2;
              hit = i;
            end
          end
        end
        if (hit >= 0) begin
          r.matched = 1'b1;
          r.landmark_index = 8'(hit);
          r.newly_verified = !cone_verified[hit];
          cone_verified[hit] = 1'b1;
          cone_x[hit] = (9 * cone_x[hit] + ox) / 10;
          cone_y[hit] = (9 * cone_y[hit] + oy) / 10;
        end else if (cone_count < TABLE_SIZE) begin
          r.landmark_index = 8'(cone_count);
          cone_x[cone_count] = ox;
          cone_y[cone_count] = oy;
          cone_color[cone_count] = b.cone_color;
          cone_verified[cone_count] = 1'b0;
          cone_count++;
        end else begin
          r.table_full = 1'b1;
        end
      end
      r.pose_x = 24'(pose_x);
      r.pose_y = 24'(pose_y);
      r.pose_heading = heading;
      pending_results = {pending_results, r};
    endfunction

    function void check_result(beat_out_t got);
      beat_out_t exp;
      if (pending_results.size() == 0) begin
        $error("result beat with no prediction waiting");
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (got.landmark_index !== exp.landmark_index) begin
        $error("landmark_index expected %0d actual %0d", exp.landmark_index,
               got.landmark_index);
        errors++;
      end
      if (got.matched !== exp.matched) begin
        $error("matched expected %0d actual %0d", exp.matched, got.matched);
        errors++;
      end
      if (got.newly_verified !== exp.newly_verified) begin
        $error("newly_verified expected %0d actual %0d", exp.newly_verified,
               got.newly_verified);
        errors++;
      end
      if (got.table_full !== exp.table_full) begin
        $error("table_full expected %0d actual %0d", exp.table_full, got.table_full);
        errors++;
      end
      if (got.pose_x !== exp.pose_x) begin
        $error("pose_x expected %0d actual %0d", exp.pose_x, got.pose_x);
        errors++;
      end
      if (got.pose_y !== exp.pose_y) begin
        $error("pose_y expected %0d actual %0d", exp.pose_y, got.pose_y);
        errors++;
      end
      if (got.pose_heading !== exp.pose_heading) begin
        $error("pose_heading expected %0d actual %0d", exp.pose_heading,
               got.pose_heading);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  bit                   quiet;
  bit                   hold_request;
  longint               cycles;
  association_scoreboard sb;

  lat_in_if in_ch ();
  lat_out_if out_ch ();

  landmark_association_table DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    beat_out_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.landmark_index = out_ch.landmark_index;
      got.matched = out_ch.matched;
      got.newly_verified = out_ch.newly_verified;
      got.table_full = out_ch.table_full;
      got.pose_x = out_ch.pose_x;
      got.pose_y = out_ch.pose_y;
      got.pose_heading = out_ch.pose_heading;
      sb.check_result(got);
    end
  end

  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ch.ready = 1'b0;
        repeat (299) @(negedge clk);
        hold_request = 1'b0;
      end else if (quiet) begin
        out_ch.ready = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ch.ready = 1'b0;
        n = $urandom_range(1, 12);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
        n = $urandom_range(1, 20);
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  task automatic send_beat(beat_in_t b);
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 12);
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.mode = b.mode;
    in_ch.vel_forward = b.vel_forward;
    in_ch.vel_lateral = b.vel_lateral;
    in_ch.yaw_rate = b.yaw_rate;
    in_ch.obs_range = b.obs_range;
    in_ch.obs_bearing = b.obs_bearing;
    in_ch.cone_color = b.cone_color;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(b);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    sb.set_register(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic beat_in_t odometry(int vf, int vl, int yr);
    beat_in_t b;
    b = '{default: '0};
    b.mode = MODE_ODOM;
    b.vel_forward = 16'(vf);
    b.vel_lateral = 16'(vl);
    b.yaw_rate = 16'(yr);
    b.obs_range = 16'($urandom);
    b.obs_bearing = 16'($urandom);
    b.cone_color = 2'($urandom);
    return b;
  endfunction

  function automatic beat_in_t observation(int rng, int brg, int col);
    beat_in_t b;
    b = odometry($urandom, $urandom, $urandom);
    b.mode = MODE_OBS;
    b.obs_range = 16'(rng);
    b.obs_bearing = 16'(brg);
    b.cone_color = 2'(col);
    return b;
  endfunction

  function automatic beat_in_t random_beat(int obs_percent);
    int ranges [4] = '{600, 2500, 6000, 15000};
    if ($urandom_range(0, 99) < obs_percent) begin
      if ($urandom_range(0, 3) != 0)
        return observation(ranges[$urandom_range(0, 3)] + $urandom_range(0, 200),
                           $urandom_range(0, 7) * 8192 + $urandom_range(0, 300),
                           $urandom_range(0, 3));
      return observation($urandom, $urandom, $urandom);
    end
    if ($urandom_range(0, 3) != 0)
      return odometry($urandom_range(0, 1024) - 512, $urandom_range(0, 256) - 128,
                      $urandom_range(0, 4096) - 2048);
    return odometry($urandom, $urandom, $urandom);
  endfunction

  task automatic random_phase(int count, int obs_percent);
    for (int i = 0; i < count; i++) begin
      if (i == 40 && !quiet) hold_request = 1'b1;
      send_beat(random_beat(obs_percent));
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_ODOM;
    in_ch.vel_forward = '0;
    in_ch.vel_lateral = '0;
    in_ch.yaw_rate = '0;
    in_ch.obs_range = '0;
    in_ch.obs_bearing = '0;
    in_ch.cone_color = '0;
    quiet = 1'b0;
    hold_request = 1'b0;
    cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_beat(odometry(0, 0, 0));
    send_beat(odometry(32767, -32768, 32767));
    send_beat(odometry(-32768, 32767, -32768));
    send_beat(odometry(-1, -1, -1));
    send_beat(observation(0, 0, 0));
    send_beat(observation(3000, 0, 1));
    send_beat(observation(3000, 0, 1));
    send_beat(observation(3010, 5, 1));
    send_beat(observation(3000, 16384, 2));
    send_beat(observation(3000, 32768, 3));
    send_beat(observation(5100, 32768, 3));
    send_beat(observation(3000, 49152, 0));
    send_beat(observation(65535, 65535, 3));
    send_beat(observation(65535, 0, 2));
    send_beat(observation(65535, 32768, 2));
    send_beat(observation(1, 16383, 0));
    send_beat(odometry(1000, 200, 16384));
    send_beat(observation(3000, 0, 1));

    drain();
    write_register(CFG_THR, 16'd3000);
    write_register(CFG_TSTEP, 16'd1311);
    random_phase(120, 60);

    drain();
    write_register(CFG_THR, 16'd0);
    write_register(CFG_TSTEP, 16'd65535);
    for (int i = 0; i < 30; i++) send_beat(odometry(32767, 32767, 0));
    random_phase(180, 90);

    drain();
    write_register(CFG_THR, 16'd65535);
    write_register(CFG_TSTEP, 16'd0);
    random_phase(60, 60);

    drain();
    write_register(CFG_THR, 16'd2048);
    write_register(CFG_TSTEP, 16'd20000);
    quiet = 1'b1;
    random_phase(60, 60);

    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> landmark_association_table.f
+incdir+rtl
rtl/lat_pkg.sv
rtl/lat_if.sv
rtl/lat_cordic.sv
rtl/landmark_association_table.sv
tb/landmark_association_table_tb.sv
